// ===== sv/bfiq_pkg.sv =====
// ----------------------------------------------------------------------------
// bfiq_pkg
// Types, hash constants and a remainder helper shared by the bloom filter blocks.
// ----------------------------------------------------------------------------
package bfiq_pkg;

   localparam int MAX_FILTER_BITS = 65536;
   localparam int MAX_KEY_BITS    = 64;
   localparam int WORD_COUNT      = MAX_FILTER_BITS / 64;
   localparam int ADDR_W          = $clog2(WORD_COUNT);
   localparam int POS_W           = $clog2(MAX_FILTER_BITS);
   localparam int MOD_W           = POS_W + 1;

   localparam logic [63:0] MM_C1  = 64'h87c37b91114253d5;
   localparam logic [63:0] MM_C2  = 64'h4cf5ad432745937f;
   localparam logic [63:0] MM_FM1 = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MM_FM2 = 64'hc4ceb93e5ec53a63;

   localparam logic [1:0] CSR_HASH_COUNT  = 2'd0;
   localparam logic [1:0] CSR_FILTER_BITS = 2'd1;
   localparam logic [1:0] CSR_HASH_SEED   = 2'd2;

   localparam logic [5:0]  RST_HASH_COUNT  = 6'd4;
   localparam logic [16:0] RST_FILTER_BITS = 17'd4793;
   localparam logic [31:0] RST_HASH_SEED   = 32'd100;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_QUERY  = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // hashed transaction handed from front to back
   typedef struct packed {
      mode_type    mode;
      logic [63:0] h0;
      logic [63:0] h1;
   } bfiq_job_type;

   typedef struct packed {
      logic [5:0]       hash_count;
      logic [MOD_W-1:0] modulus;
   } bfiq_cfg_type;

   // four restoring remainder steps, MSB first
   function automatic logic [POS_W-1:0] mod_step4(input logic [POS_W-1:0] r,
                                                  input logic [3:0] bits,
                                                  input logic [MOD_W-1:0] m);
      logic [POS_W-1:0] acc;
      logic [MOD_W-1:0] t;
      acc = r;
      for (int k = 3; k >= 0; k--) begin
         t = {acc, bits[k]};
         if (t >= m) begin
            t = t - m;
         end
         acc = t[POS_W-1:0];
      end
      return acc;
   endfunction

endpackage

// ===== sv/bfiq_front.sv =====
// ----------------------------------------------------------------------------
// bfiq_front
// Accepts transactions, hashes keys with MurmurHash3 x64 128 on a shared
// 32x32 multiplier (three partial products per 64-bit multiply).
// ----------------------------------------------------------------------------
module bfiq_front
   import bfiq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [63:0]        req_key_value,
   input  logic [6:0]         req_key_length_bits,
   input  logic [31:0]        hash_seed,
   input  logic               hold,
   output logic               push,
   output bfiq_job_type       push_job,
   input  logic               q_full
);

   typedef enum logic [3:0] {
      F_IDLE, F_K1A, F_K1B, F_SEED, F_ADD1, F_ADD2,
      F_M1, F_M2, F_M3, F_M4, F_ADD3, F_ADD4, F_PUSH
   } fstate_type;

   fstate_type  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] h1_ff, h1_in;
   logic [63:0] h2_ff, h2_in;
   logic [3:0]  nb_ff, nb_in;
   mode_type    mode_ff, mode_in;

   logic [63:0] mul_c;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [63:0] prod;
   logic        is_mul;
   logic [6:0]  len_c;
   logic [3:0]  nbytes;
   logic [63:0] key_mask;
   logic [63:0] seed64;

   always_comb begin
      unique case (state_ff)
         F_K1A:        mul_c = MM_C1;
         F_K1B:        mul_c = MM_C2;
         F_M1, F_M3:   mul_c = MM_FM1;
         default:      mul_c = MM_FM2;
      endcase
   end

   assign is_mul = (state_ff == F_K1A) || (state_ff == F_K1B) || (state_ff == F_M1) ||
                   (state_ff == F_M2) || (state_ff == F_M3) || (state_ff == F_M4);

   always_comb begin
      unique case (phase_ff)
         2'd0:    begin mul_a = x_ff[31:0];  mul_b = mul_c[31:0];  end
         2'd1:    begin mul_a = x_ff[31:0];  mul_b = mul_c[63:32]; end
         default: begin mul_a = x_ff[63:32]; mul_b = mul_c[31:0];  end
      endcase
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
   assign prod  = {acc_ff[63:32] + mul_p[31:0], acc_ff[31:0]};

   assign len_c  = (req_key_length_bits > 7'(MAX_KEY_BITS)) ? 7'(MAX_KEY_BITS)
                                                              : req_key_length_bits;
   assign nbytes = 4'((len_c + 7'd7) >> 3);
   assign key_mask = (nbytes >= 4'd8) ? {64{1'b1}}
                                      : ((64'd1 << {nbytes[2:0], 3'b000}) - 64'd1);
   assign seed64 = {32'd0, hash_seed};

   assign req_ready = (state_ff == F_IDLE) && !hold;
   assign push      = (state_ff == F_PUSH) && !q_full;
   assign push_job  = '{mode: mode_ff, h0: h1_ff, h1: h2_ff};

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      x_in     = x_ff;
      acc_in   = acc_ff;
      h1_in    = h1_ff;
      h2_in    = h2_ff;
      nb_in    = nb_ff;
      mode_in  = mode_ff;
      if (is_mul) begin
         unique case (phase_ff)
            2'd0:    begin acc_in = mul_p; phase_in = 2'd1; end
            2'd1:    begin acc_in = prod;  phase_in = 2'd2; end
            default: phase_in = 2'd0;
         endcase
      end
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && req_ready) begin
               mode_in = mode_type'(req_mode);
               nb_in   = nbytes;
               x_in    = req_key_value & key_mask;
               phase_in = 2'd0;
               if (req_mode == MODE_INSERT || req_mode == MODE_QUERY) begin
                  state_in = F_K1A;
               end else begin
                  state_in = F_PUSH;
               end
            end
         end
         F_K1A: if (phase_ff == 2'd2) begin
            x_in = {prod[32:0], prod[63:33]};   // rotl 31
            state_in = F_K1B;
         end
         F_K1B: if (phase_ff == 2'd2) begin
            x_in = prod;
            state_in = F_SEED;
         end
         F_SEED: begin
            h1_in = seed64 ^ x_ff ^ {60'd0, nb_ff};
            h2_in = seed64 ^ {60'd0, nb_ff};
            state_in = F_ADD1;
         end
         F_ADD1: begin
            h1_in = h1_ff + h2_ff;
            state_in = F_ADD2;
         end
         F_ADD2: begin
            h2_in = h2_ff + h1_ff;
            x_in  = h1_ff ^ (h1_ff >> 33);
            state_in = F_M1;
         end
         F_M1, F_M3: if (phase_ff == 2'd2) begin
            x_in = prod ^ (prod >> 33);
            state_in = (state_ff == F_M1) ? F_M2 : F_M4;
         end
         F_M2: if (phase_ff == 2'd2) begin
            h1_in = prod ^ (prod >> 33);
            x_in  = h2_ff ^ (h2_ff >> 33);
            state_in = F_M3;
         end
         F_M4: if (phase_ff == 2'd2) begin
            h2_in = prod ^ (prod >> 33);
            state_in = F_ADD3;
         end
         F_ADD3: begin
            h1_in = h1_ff + h2_ff;
            state_in = F_ADD4;
         end
         F_ADD4: begin
            h2_in = h2_ff + h1_ff;
            state_in = F_PUSH;
         end
         F_PUSH: if (!q_full) begin
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         phase_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      h1_ff   <= h1_in;
      h2_ff   <= h2_in;
      nb_ff   <= nb_in;
      mode_ff <= mode_in;
   end

endmodule

// ===== sv/bfiq_queue.sv =====
// ----------------------------------------------------------------------------
// bfiq_queue
// Two-entry queue of hashed transactions between front and back.
// ----------------------------------------------------------------------------
module bfiq_queue
   import bfiq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bfiq_job_type push_job,
   output logic         full,
   input  logic         pop,
   output bfiq_job_type head,
   output logic         empty
);

   bfiq_job_type slot_ff [2];
   logic         wr_ff, wr_in;
   logic         rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue underflow");
   a_count_move: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("queue count did not advance");
`endif

endmodule

// ===== sv/bfiq_back.sv =====
// ----------------------------------------------------------------------------
// bfiq_back
// Reduces hashes modulo filter size, probes the bit memory, runs clears and
// holds the result register.
// ----------------------------------------------------------------------------
module bfiq_back
   import bfiq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  bfiq_cfg_type cfg,
   input  logic         q_empty,
   input  bfiq_job_type head,
   output logic         pop,
   output logic         init_busy,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         rsp_present
);

   typedef enum logic [2:0] {
      B_CLEAR, B_IDLE, B_MOD, B_READ, B_UPDATE, B_DONE
   } bstate_type;

   bstate_type       state_ff, state_in;
   logic             init_ff, init_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   mode_type         mode_ff, mode_in;
   logic [63:0]      sh0_ff, sh0_in;
   logic [63:0]      sh1_ff, sh1_in;
   logic [63:0]      acc_ff, acc_in;
   logic [63:0]      step_ff, step_in;
   logic [POS_W-1:0] r_ff, r_in;
   logic [POS_W-1:0] d_ff, d_in;
   logic [POS_W-1:0] w_ff, w_in;
   logic [POS_W-1:0] t_ff, t_in;
   logic             carry_ff, carry_in;
   logic [3:0]       mcnt_ff, mcnt_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [ADDR_W-1:0] word_ff, word_in;
   logic [5:0]       bit_ff, bit_in;
   logic             all_ff, all_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_present_ff, rsp_present_in;

   logic [63:0]      mem [WORD_COUNT];
   logic [63:0]      rdata_ff;
   logic             mem_re;
   logic [ADDR_W-1:0] mem_raddr;
   logic             mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [63:0]      mem_wdata;

   logic [64:0]      sum65;
   logic [MOD_W-1:0] tsum;
   logic [MOD_W-1:0] tfix;
   logic [MOD_W-1:0] twrap;
   logic [POS_W-1:0] r_next;
   logic             last_probe;
   logic             out_free;

   assign init_busy   = init_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign pop         = (state_ff == B_IDLE) && !q_empty;

   assign sum65 = {1'b0, acc_ff} + {1'b0, step_ff};
   assign tsum  = {1'b0, r_ff} + {1'b0, d_ff};
   assign tfix  = (tsum >= cfg.modulus) ? (tsum - cfg.modulus) : tsum;
   // undo the 2^64 wrap: subtract 2^64 mod m
   assign twrap = ({1'b0, t_ff} >= {1'b0, w_ff}) ? ({1'b0, t_ff} - {1'b0, w_ff})
                : ({1'b0, t_ff} + cfg.modulus - {1'b0, w_ff});
   assign r_next = carry_ff ? twrap[POS_W-1:0] : t_ff;
   assign last_probe = ({1'b0, cnt_ff} + 7'd1) == {1'b0, cfg.hash_count};

   assign mem_re    = (state_ff == B_READ);
   assign mem_raddr = r_ff[POS_W-1:6];
   assign mem_we    = (state_ff == B_CLEAR) ||
                      ((state_ff == B_UPDATE) && (mode_ff == MODE_INSERT));
   assign mem_waddr = (state_ff == B_CLEAR) ? clr_ff : word_ff;
   assign mem_wdata = (state_ff == B_CLEAR) ? 64'd0 : (rdata_ff | (64'd1 << bit_ff));

   always_comb begin
      state_in       = state_ff;
      init_in        = init_ff;
      clr_in         = clr_ff;
      mode_in        = mode_ff;
      sh0_in         = sh0_ff;
      sh1_in         = sh1_ff;
      acc_in         = acc_ff;
      step_in        = step_ff;
      r_in           = r_ff;
      d_in           = d_ff;
      w_in           = w_ff;
      t_in           = t_ff;
      carry_in       = carry_ff;
      mcnt_in        = mcnt_ff;
      cnt_in         = cnt_ff;
      word_in        = word_ff;
      bit_in         = bit_ff;
      all_in         = all_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_present_in = rsp_present_ff;
      unique case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(WORD_COUNT - 1)) begin
               init_in  = 1'b0;
               all_in   = 1'b0;
               state_in = init_ff ? B_IDLE : B_DONE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               mode_in = head.mode;
               sh0_in  = head.h0;
               sh1_in  = head.h1;
               acc_in  = head.h0;
               step_in = head.h1;
               r_in    = '0;
               d_in    = '0;
               w_in    = (cfg.modulus == MOD_W'(1)) ? POS_W'(0) : POS_W'(1);
               mcnt_in = 4'd0;
               cnt_in  = 6'd0;
               all_in  = 1'b1;
               clr_in  = '0;
               unique case (head.mode)
                  MODE_INSERT, MODE_QUERY: state_in = B_MOD;
                  MODE_CLEAR:              state_in = B_CLEAR;
                  default: begin
                     all_in   = 1'b0;
                     state_in = B_DONE;
                  end
               endcase
            end
         end
         B_MOD: begin
            r_in    = mod_step4(r_ff, sh0_ff[63:60], cfg.modulus);
            d_in    = mod_step4(d_ff, sh1_ff[63:60], cfg.modulus);
            w_in    = mod_step4(w_ff, 4'd0, cfg.modulus);
            sh0_in  = sh0_ff << 4;
            sh1_in  = sh1_ff << 4;
            mcnt_in = mcnt_ff + 4'd1;
            if (mcnt_ff == 4'd15) begin
               if (cfg.hash_count == 6'd0) begin
                  all_in   = (mode_ff == MODE_QUERY);
                  state_in = B_DONE;
               end else begin
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            word_in  = r_ff[POS_W-1:6];
            bit_in   = r_ff[5:0];
            acc_in   = sum65[63:0];
            carry_in = sum65[64];
            t_in     = tfix[POS_W-1:0];
            state_in = B_UPDATE;
         end
         B_UPDATE: begin
            if (mode_ff == MODE_QUERY) begin
               all_in = all_ff & rdata_ff[bit_ff];
            end
            r_in   = r_next;
            cnt_in = cnt_ff + 6'd1;
            if (last_probe) begin
               state_in = B_DONE;
            end else begin
               state_in = B_READ;
            end
         end
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = (mode_ff == MODE_QUERY) && all_ff;
               state_in       = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      sh0_ff         <= sh0_in;
      sh1_ff         <= sh1_in;
      acc_ff         <= acc_in;
      step_ff        <= step_in;
      r_ff           <= r_in;
      d_ff           <= d_in;
      w_ff           <= w_in;
      t_ff           <= t_in;
      carry_ff       <= carry_in;
      mcnt_ff        <= mcnt_in;
      cnt_ff         <= cnt_in;
      word_ff        <= word_in;
      bit_ff         <= bit_in;
      all_ff         <= all_in;
      rsp_present_ff <= rsp_present_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

`ifndef SYNTHESIS
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_READ) |-> ({1'b0, r_ff} < cfg.modulus))
      else $error("probe position not below modulus");
   a_probe_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_UPDATE) |-> ({1'b0, cnt_ff} < {1'b0, cfg.hash_count}))
      else $error("probe past hash count");
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_CLEAR && clr_ff == ADDR_W'(WORD_COUNT - 1)) |=> (state_ff != B_CLEAR))
      else $error("clear sweep did not end");
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      init_ff |-> !pop)
      else $error("transaction taken during reset clear");
`endif

endmodule

// ===== sv/bloom_filter_insert_query.sv =====
// Flow: the front hashes the key on the shared 32x32 multiplier, the job crosses
//   the queue, the back reduces both hashes modulo the filter size and then reads
//   the memory for each probe, writing it back on insert; a clear sweeps it all.
//   The front can hash the next transaction while the back is still busy.
// Reset: synchronous; a sweep then zeroes all 1024 words of the filter memory,
//   with req_ready low meanwhile (configuration writes still taken).
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// Bloom filter with insert, query and clear over a 64K-bit memory.
// ----------------------------------------------------------------------------
module bloom_filter_insert_query
   import bfiq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [63:0] req_key_value,
   input  logic [6:0]  req_key_length_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_present,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [5:0]   hash_count_ff;
   logic [16:0]  filter_bits_ff;
   logic [31:0]  hash_seed_ff;
   bfiq_cfg_type cfg;
   logic         hold;
   logic         push;
   bfiq_job_type push_job;
   logic         q_full;
   logic         q_empty;
   logic         pop;
   bfiq_job_type head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_count_ff  <= RST_HASH_COUNT;
         filter_bits_ff <= RST_FILTER_BITS;
         hash_seed_ff   <= RST_HASH_SEED;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_HASH_COUNT:  hash_count_ff  <= csr_data[5:0];
            CSR_FILTER_BITS: filter_bits_ff <= csr_data[16:0];
            CSR_HASH_SEED:   hash_seed_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.hash_count = hash_count_ff;
      if (filter_bits_ff == 17'd0) begin
         cfg.modulus = MOD_W'(1);
      end else if (filter_bits_ff > 17'(MAX_FILTER_BITS)) begin
         cfg.modulus = MOD_W'(MAX_FILTER_BITS);
      end else begin
         cfg.modulus = filter_bits_ff;
      end
   end

   bfiq_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_key_value       (req_key_value),
      .req_key_length_bits (req_key_length_bits),
      .hash_seed           (hash_seed_ff),
      .hold                (hold),
      .push                (push),
      .push_job            (push_job),
      .q_full              (q_full)
   );

   bfiq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   bfiq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_empty     (q_empty),
      .head        (head),
      .pop         (pop),
      .init_busy   (hold),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_present (rsp_present)
   );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Bloom filter insert/query/clear bench: a shadow filter with its own
// MurmurHash3 x64 128 predicts every presence answer, checked in order.
// ----------------------------------------------------------------------------

import bfiq_pkg::*;

class bloom_shadow;

   bit [63:0]   filter_mem [WORD_COUNT];
   bit [5:0]    probes;
   bit [16:0]   bit_span;
   bit [31:0]   seed;
   bit          present_q [$];
   int unsigned fail_count;
   int unsigned item_count;
   int unsigned hit_count;
   int unsigned csr_count;

   function new();
      foreach (filter_mem[w]) filter_mem[w] = '0;
      probes   = RST_HASH_COUNT;
      bit_span = RST_FILTER_BITS;
      seed     = RST_HASH_SEED;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] data);
      csr_count++;
      case (idx)
         CSR_HASH_COUNT:  probes   = data[5:0];
         CSR_FILTER_BITS: bit_span = data[16:0];
         CSR_HASH_SEED:   seed     = data;
         default: ;
      endcase
   endfunction

   function bit [63:0] fmix(bit [63:0] k);
      k = k ^ (k >> 33);
      k = k * 64'hff51afd7ed558ccd;
      k = k ^ (k >> 33);
      k = k * 64'hc4ceb93e5ec53a63;
      k = k ^ (k >> 33);
      return k;
   endfunction

   // hashes the low key bytes of inserts and queries and applies the transaction to the shadow memory
   function void note_request(mode_type mode, bit [63:0] key, bit [6:0] len);
      bit [63:0] ha, hb, k1, span, pos;
      int unsigned nbytes, ln;
      bit all_set;
      item_count++;
      all_set = 1'b1;
      if (mode == MODE_CLEAR) begin
         foreach (filter_mem[w]) filter_mem[w] = '0;
         present_q.push_back(1'b0);
         return;
      end
      if (mode == MODE_NONE) begin
         present_q.push_back(1'b0);
         return;
      end
      ln = (len > MAX_KEY_BITS) ? MAX_KEY_BITS : len;
      nbytes = (ln >> 3) + ((ln & 7) != 0);
      span = (bit_span == 0) ? 64'd1 :
             (bit_span > MAX_FILTER_BITS) ? 64'(MAX_FILTER_BITS) : 64'(bit_span);
      ha = 64'(seed);
      hb = 64'(seed);
      if (nbytes > 0) begin
         k1 = key;
         if (nbytes < 8) k1 = k1 & ((64'd1 << (8 * nbytes)) - 64'd1);
         k1 = k1 * 64'h87c37b91114253d5;
         k1 = (k1 << 31) | (k1 >> 33);
         k1 = k1 * 64'h4cf5ad432745937f;
         ha = ha ^ k1;
      end
      ha = ha ^ 64'(nbytes);
      hb = hb ^ 64'(nbytes);
      ha = ha + hb;
      hb = hb + ha;
      ha = fmix(ha);
      hb = fmix(hb);
      ha = ha + hb;
      hb = hb + ha;
      for (int i = 0; i < probes; i++) begin
         pos = (ha + 64'(i) * hb) % span;
         if (mode == MODE_INSERT) filter_mem[pos >> 6][pos[5:0]] = 1'b1;
         else all_set &= filter_mem[pos >> 6][pos[5:0]];
      end
      if (mode == MODE_QUERY && all_set) hit_count++;
      present_q.push_back(mode == MODE_QUERY ? all_set : 1'b0);
   endfunction

   function void check_present(bit got);
      bit want;
      if (present_q.size() == 0) begin
         $error("present: result with no transaction pending, actual %0b", got);
         fail_count++;
         return;
      end
      want = present_q.pop_front();
      if (want !== got) begin
         $error("present: expected %0b actual %0b", want, got);
         fail_count++;
      end
   endfunction
endclass

module tb_top;
   import bfiq_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 1200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_mode = MODE_INSERT;
   logic [63:0] req_key_value = '0;
   logic [6:0]  req_key_length_bits = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_present;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_HASH_COUNT;
   logic [31:0] csr_data = '0;

   bloom_shadow shadow = new();
   bit          quiet;
   bit          hold_rsp;
   int unsigned idle_cycles;
   logic [63:0] key_pool [$];
   logic [6:0]  len_pool [$];

   bloom_filter_insert_query dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_valid && rsp_ready) begin
            shadow.check_present(rsp_present);
         end
         if (req_valid && req_ready) begin
            shadow.note_request(mode_type'(req_mode), req_key_value, req_key_length_bits);
         end
         if (csr_valid && csr_ready) begin
            shadow.write_reg(csr_index, csr_data);
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bloom_filter_insert_query verification failed");
            $finish;
         end
      end
   end

   task automatic send_item(mode_type mode, logic [63:0] key, logic [6:0] len);
      req_valid           <= 1'b1;
      req_mode            <= mode;
      req_key_value       <= key;
      req_key_length_bits <= len;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // drop valid, wait for every answer, then let a clear sweep finish
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (shadow.present_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly inserts and queries over a small key pool so queries hit
   task automatic random_item();
      int unsigned r, pick;
      logic [63:0] key;
      logic [6:0]  len;
      r   = $urandom_range(0, 99);
      key = {$urandom, $urandom};
      len = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                        : 7'($urandom_range(1, 64));
      if (key_pool.size() != 0 && $urandom_range(0, 99) < 60 && r < 90) begin
         pick = $urandom_range(0, key_pool.size() - 1);
         key  = key_pool[pick];
         len  = len_pool[pick];
      end
      if (r < 40) begin
         send_item(MODE_INSERT, key, len);
         key_pool.push_back(key);
         len_pool.push_back(len);
         if (key_pool.size() > 16) begin
            void'(key_pool.pop_front());
            void'(len_pool.pop_front());
         end
      end else if (r < 93) begin
         send_item(MODE_QUERY, key, len);
      end else if (r < 96) begin
         send_item(MODE_CLEAR, key, len);
         key_pool.delete();
         len_pool.delete();
      end else begin
         send_item(MODE_NONE, key, len);
      end
   endtask

   initial begin
      logic [5:0]  hc_set [7] = '{1, 63, 0, 32, 7, 12, 3};
      logic [31:0] fb_set [7] = '{1, 0, 65536, 131071, 64, 1000, 65535};
      logic [31:0] sd_set [7];
      sd_set = '{0, 32'hFFFF_FFFF, $urandom, 32'h1234_5678, $urandom, $urandom, $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every mode, partial bytes, length clamp
      send_item(MODE_QUERY,  64'h0, 7'd1);
      send_item(MODE_INSERT, 64'h0, 7'd1);
      send_item(MODE_QUERY,  64'h0, 7'd1);
      send_item(MODE_QUERY,  64'hFF00, 7'd1);
      send_item(MODE_INSERT, '1, 7'd64);
      send_item(MODE_QUERY,  '1, 7'd64);
      send_item(MODE_QUERY,  '1, 7'd127);
      send_item(MODE_QUERY,  '1, 7'd65);
      send_item(MODE_INSERT, 64'h5, 7'd0);
      send_item(MODE_QUERY,  64'hABCD, 7'd0);
      send_item(MODE_INSERT, 64'hFF, 7'd3);
      send_item(MODE_QUERY,  64'h07, 7'd3);
      send_item(MODE_QUERY,  64'hFF, 7'd3);
      send_item(MODE_INSERT, 64'h8000_0000_0000_0001, 7'd63);
      send_item(MODE_QUERY,  64'h8000_0000_0000_0001, 7'd63);
      send_item(MODE_NONE,   '1, 7'd64);
      send_item(MODE_CLEAR,  64'h0, 7'd0);
      send_item(MODE_QUERY,  '1, 7'd64);
      send_item(MODE_QUERY,  64'h0, 7'd1);
      drain();

      for (int p = 0; p < 7; p++) begin
         write_csr(CSR_HASH_COUNT,  32'(hc_set[p]));
         write_csr(CSR_FILTER_BITS, fb_set[p]);
         write_csr(CSR_HASH_SEED,   sd_set[p]);
         @(posedge clock);
         quiet = (p == 6);
         for (int n = 0; n < 185; n++) begin
            if (p == 2 && n == 40) hold_rsp = 1'b1;
            if (p == 3 && n == 90) drain();
            random_item();
         end
         drain();
      end

      $display("%0d transactions (%0d query hits), %0d register writes, 7 settings",
               shadow.item_count, shadow.hit_count, shadow.csr_count);
      $display("covered probe counts from 0 up to 63, clamped spans and both seed extremes");
      if (shadow.fail_count == 0) begin
         $display("bloom_filter_insert_query verification clean");
      end else begin
         $display("bloom_filter_insert_query verification failed");
      end
      $finish;
   end

endmodule
